@@ design/sha512_pkg.sv @@
// Package for the SHA-512 hash engine: constants, controller states,
// command/status structs and the round functions. No dependencies.
package sha512_pkg;

  localparam int WordW = 64;
  localparam int BlockWords = 16;
  localparam int Rounds = 80;
  localparam int DigestWords = 8;
  localparam int LenW = 61;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_EMIT
  } ctrl_state_t;

  // Word-load selection for the block buffer.
  typedef enum logic [2:0] {
    LD_DATA,
    LD_PAD,
    LD_MARK,
    LD_ZERO,
    LD_LEN
  } load_sel_t;

  typedef struct packed {
    logic      load;       // write one word into the block buffer
    load_sel_t load_sel;
    logic      add_len;    // add the beat's byte count to the length
    logic      len_full;   // count the beat as eight bytes
    logic      init_vars;  // copy hash state into a..h
    logic      round;      // run one round
    logic      fold;       // add a..h into the hash state
    logic      restart;    // reload initial hash, clear length and position
  } dp_cmd_t;

  typedef struct packed {
    logic [3:0] word_pos;
    logic [6:0] round_idx;
  } dp_status_t;

  function automatic logic [WordW-1:0] init_h(input logic [2:0] i);
    case (i)
      3'd0: init_h = 64'h6a09e667f3bcc908;
      3'd1: init_h = 64'hbb67ae8584caa73b;
      3'd2: init_h = 64'h3c6ef372fe94f82b;
      3'd3: init_h = 64'ha54ff53a5f1d36f1;
      3'd4: init_h = 64'h510e527fade682d1;
      3'd5: init_h = 64'h9b05688c2b3e6c1f;
      3'd6: init_h = 64'h1f83d9abfb41bd6b;
      default: init_h = 64'h5be0cd19137e2179;
    endcase
  endfunction

  localparam logic [WordW-1:0] RCONST [Rounds] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;

  function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] x, input int n);
    rotr = (x >> n) | (x << (WordW - n));
  endfunction

endpackage

@@ design/sha512_datapath.sv @@
// Datapath of the SHA-512 engine: hash state, round variables, block buffer,
// length counter and the one-round-per-cycle compression logic. Uses sha512_pkg.
module sha512_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  sha512_pkg::dp_cmd_t               cmd,
  output sha512_pkg::dp_status_t            status,
  input  logic [sha512_pkg::WordW-1:0]      data_word,
  input  logic [3:0]                        byte_count,
  input  logic [2:0]                        rd_index,
  output logic [sha512_pkg::WordW-1:0]      rd_word
);

  logic [sha512_pkg::WordW-1:0] hash_state [sha512_pkg::DigestWords];
  logic [sha512_pkg::WordW-1:0] vars [8];
  logic [sha512_pkg::WordW-1:0] buffer [sha512_pkg::BlockWords];
  logic [3:0]                   word_pos;
  logic [6:0]                   round_idx;
  logic [sha512_pkg::LenW-1:0]  msg_bytes;

  logic [3:0]                   cnt;
  logic [6:0]                   sh;
  logic [sha512_pkg::WordW-1:0] mask, pad_word, load_word;
  logic [3:0]                   r0;
  logic [sha512_pkg::WordW-1:0] w15, w2, w7, wnew, wr, s0, s1, t1, t2, ch, maj, e1, e0;

  assign cnt = (byte_count > 4'd8) ? 4'd8 : byte_count;

  always_comb begin
    sh   = 7'd64 - {cnt, 3'b000};
    mask = (cnt == 4'd0) ? '0 : ~(64'hffff_ffff_ffff_ffff >> {cnt, 3'b000});
    pad_word = (data_word & mask) |
               ((cnt == 4'd8) ? 64'd0 : ({56'd0, sha512_pkg::PAD_BYTE} << (sh - 7'd8)));
    case (cmd.load_sel)
      sha512_pkg::LD_DATA: load_word = data_word;
      sha512_pkg::LD_PAD:  load_word = pad_word;
      sha512_pkg::LD_MARK: load_word = {sha512_pkg::PAD_BYTE, 56'd0};
      sha512_pkg::LD_ZERO: load_word = '0;
      sha512_pkg::LD_LEN:  load_word = {msg_bytes, 3'b000};
      default:             load_word = '0;
    endcase
  end

  // Rolling schedule: slot r mod 16 holds w[r-16] before it is overwritten.
  always_comb begin
    r0  = round_idx[3:0];
    w15 = buffer[r0 + 4'd1];
    w2  = buffer[r0 + 4'd14];
    w7  = buffer[r0 + 4'd9];
    s0  = sha512_pkg::rotr(w15, 1) ^ sha512_pkg::rotr(w15, 8) ^ (w15 >> 7);
    s1  = sha512_pkg::rotr(w2, 19) ^ sha512_pkg::rotr(w2, 61) ^ (w2 >> 6);
    wnew = buffer[r0] + s0 + w7 + s1;
    wr  = (round_idx < 7'd16) ? buffer[r0] : wnew;
    e1  = sha512_pkg::rotr(vars[4], 14) ^ sha512_pkg::rotr(vars[4], 18) ^
          sha512_pkg::rotr(vars[4], 41);
    ch  = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
    e0  = sha512_pkg::rotr(vars[0], 28) ^ sha512_pkg::rotr(vars[0], 34) ^
          sha512_pkg::rotr(vars[0], 39);
    maj = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
    t1  = vars[7] + e1 + ch + sha512_pkg::RCONST[round_idx] + wr;
    t2  = e0 + maj;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_pos  <= '0;
      round_idx <= '0;
      msg_bytes <= '0;
      for (int i = 0; i < 8; i++) hash_state[i] <= sha512_pkg::init_h(3'(i));
    end else begin
      if (cmd.restart) begin
        word_pos  <= '0;
        msg_bytes <= '0;
        for (int i = 0; i < 8; i++) hash_state[i] <= sha512_pkg::init_h(3'(i));
      end
      if (cmd.load) begin
        buffer[word_pos] <= load_word;
        word_pos <= word_pos + 4'd1;
      end
      if (cmd.add_len)
        msg_bytes <= msg_bytes + (cmd.len_full ? sha512_pkg::LenW'(8) :
                                                 sha512_pkg::LenW'(cnt));
      if (cmd.init_vars) begin
        round_idx <= '0;
        for (int i = 0; i < 8; i++) vars[i] <= hash_state[i];
      end
      if (cmd.round) begin
        if (round_idx >= 7'd16) buffer[r0] <= wnew;
        vars[7] <= vars[6]; vars[6] <= vars[5]; vars[5] <= vars[4];
        vars[4] <= vars[3] + t1;
        vars[3] <= vars[2]; vars[2] <= vars[1]; vars[1] <= vars[0];
        vars[0] <= t1 + t2;
        round_idx <= round_idx + 7'd1;
      end
      if (cmd.fold)
        for (int i = 0; i < 8; i++) hash_state[i] <= hash_state[i] + vars[i];
    end
  end

  assign status.word_pos  = word_pos;
  assign status.round_idx = round_idx;
  assign rd_word = hash_state[rd_index];

endmodule

@@ design/sha512_ctrl.sv @@
// Controller of the SHA-512 engine: input handshake, block scheduling,
// padding sequence and digest output. Uses sha512_pkg.
module sha512_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    final_word,
  input  logic [3:0]              byte_count,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [2:0]              digest_index,
  output logic                    digest_done,
  output sha512_pkg::dp_cmd_t     cmd,
  input  sha512_pkg::dp_status_t  status
);

  sha512_pkg::ctrl_state_t state, state_next;
  logic       padding, padding_next;   // message ended, filling pad words
  logic       full8, full8_next;       // final beat had 8 bytes: pad word pending
  logic       len_due, len_due_next;   // zero went into slot 14: length goes next
  logic [2:0] idx, idx_next;
  logic       accept;
  // Set when the length word went in: the block being compressed is the last.
  logic       last_block, last_block_next;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= sha512_pkg::ST_IDLE;
      padding <= 1'b0;
      full8   <= 1'b0;
      len_due <= 1'b0;
      idx     <= '0;
    end else begin
      state   <= state_next;
      padding <= padding_next;
      full8   <= full8_next;
      len_due <= len_due_next;
      idx     <= idx_next;
    end
  end

  always_comb begin
    state_next   = state;
    padding_next = padding;
    full8_next   = full8;
    len_due_next = len_due;
    idx_next     = idx;
    cmd          = '0;
    cmd.load_sel = sha512_pkg::LD_DATA;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    case (state)
      sha512_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          cmd.load    = 1'b1;
          cmd.add_len = 1'b1;
          if (final_word) begin
            padding_next = 1'b1;
            if (byte_count >= 4'd8) full8_next = 1'b1;
            else cmd.load_sel = sha512_pkg::LD_PAD;
          end else begin
            // non-final beats always count eight bytes
            cmd.len_full = 1'b1;
          end
          if (status.word_pos == 4'd15) state_next = sha512_pkg::ST_INIT;
          else if (final_word) state_next = sha512_pkg::ST_PAD;
        end
      end
      sha512_pkg::ST_PAD: begin
        cmd.load = 1'b1;
        if (full8) begin
          cmd.load_sel = sha512_pkg::LD_MARK;
          full8_next   = 1'b0;
        end else if (len_due) begin
          cmd.load_sel = sha512_pkg::LD_LEN;
          padding_next = 1'b0;
          len_due_next = 1'b0;
        end else begin
          cmd.load_sel = sha512_pkg::LD_ZERO;
          if (status.word_pos == 4'd14) len_due_next = 1'b1;
        end
        if (status.word_pos == 4'd15) state_next = sha512_pkg::ST_INIT;
      end
      sha512_pkg::ST_INIT: begin
        cmd.init_vars = 1'b1;
        state_next    = sha512_pkg::ST_ROUND;
      end
      sha512_pkg::ST_ROUND: begin
        cmd.round = 1'b1;
        if (status.round_idx == 7'(sha512_pkg::Rounds - 1)) state_next = sha512_pkg::ST_FOLD;
      end
      sha512_pkg::ST_FOLD: begin
        cmd.fold = 1'b1;
        if (full8 || padding) state_next = sha512_pkg::ST_PAD;
        else if (state_next == sha512_pkg::ST_FOLD && last_block) begin
          idx_next   = '0;
          state_next = sha512_pkg::ST_EMIT;
        end else state_next = sha512_pkg::ST_IDLE;
      end
      sha512_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          idx_next = idx + 3'd1;
          if (idx == 3'd7) begin
            cmd.restart = 1'b1;
            state_next  = sha512_pkg::ST_IDLE;
          end
        end
      end
      default: state_next = sha512_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) last_block <= 1'b0;
    else     last_block <= last_block_next;
  end
  always_comb begin
    last_block_next = last_block;
    if (cmd.load && cmd.load_sel == sha512_pkg::LD_LEN) last_block_next = 1'b1;
    if (cmd.restart) last_block_next = 1'b0;
  end

  assign digest_index = idx;
  assign digest_done  = (idx == 3'd7);

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("input taken while digest pending");
  a_round_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd.round |-> status.round_idx < 7'(sha512_pkg::Rounds)) else $error("round overrun");
  a_len_last: assert property (@(posedge clk) disable iff (rst)
    (cmd.load && cmd.load_sel == sha512_pkg::LD_LEN) |-> status.word_pos == 4'd15)
    else $error("length word misplaced");
  a_restart: assert property (@(posedge clk) disable iff (rst)
    cmd.restart |=> state == sha512_pkg::ST_IDLE && !last_block)
    else $error("restart did not return to idle");

endmodule

@@ design/sha512_hash_engine_unit.sv @@
// SHA-512 hash engine: takes a message as big-endian 64-bit beats, pads it
// on the final beat and returns the eight digest words. Uses sha512_pkg.
//
// Feed one message word per input beat: data_word with its valid bytes at the
// top, byte_count (values above 8 count as 8, and non-final beats always count
// 8) and final_word on the last beat. A beat that fills a 16-word block starts
// an 80-round compression, one round per cycle, with in_ready low during
// compression. After the final beat the engine writes its pad, zero and length
// words one per cycle, pausing for the compression of each full block (at most
// two blocks), then offers digest words 0 through 7 as eight output beats,
// digest_done marking the last. No new input is taken until the eighth digest
// beat is taken; the engine then starts fresh for the next message.
module sha512_hash_engine_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] data_word,
  input  logic [3:0]  byte_count,
  input  logic        final_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] digest_word,
  output logic [2:0]  digest_index,
  output logic        digest_done
);

  sha512_pkg::dp_cmd_t    cmd;
  sha512_pkg::dp_status_t status;

  // Sequence loads, rounds and digest beats.
  sha512_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .final_word(final_word), .byte_count(byte_count),
    .out_valid(out_valid), .out_ready(out_ready),
    .digest_index(digest_index), .digest_done(digest_done),
    .cmd(cmd), .status(status)
  );

  // Hold the hash state, block buffer and message length, and compute the rounds.
  sha512_datapath u_dp (
    .clk(clk), .rst(rst),
    .cmd(cmd), .status(status),
    .data_word(data_word), .byte_count(byte_count),
    .rd_index(digest_index), .rd_word(digest_word)
  );

endmodule
